@@ sv/fbfl_pkg.sv @@
// Shared types and constants for the fixed-size block free-list allocator.
package fbfl_pkg;

    localparam int CAP_W = 7;
    localparam int IDX_FIELD_W = 6;
    localparam int COUNT_W = 7;

    localparam logic [CAP_W-1:0] CAP_FIELD_MAX = 7'd64;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_BAD_FREE = 2'd2,
        STATUS_NULL_FREE = 2'd3
    } status_t;

endpackage

@@ sv/fixed_block_free_list_allocator_core.sv @@
// Latency: a command taken on start passes through the input register and then the result register before done.
// Throughput: one command per cycle while busy is low, alloc and free in any mix; done cannot be stalled.
// The head of the free list and the next two links are held in registers, so at most one
// link table read (on an alloc) and one write (on a successful alloc or free) happen per cycle.
// After reset, and after every capacity write, busy stays high while the link table is rebuilt
// entry by entry; a pending capacity write holds busy and waits for an empty pipe.
module fixed_block_free_list_allocator_core
    import fbfl_pkg::*;
#(
    parameter int POOL_DEPTH = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   opcode,
    input  logic                   block_present,
    input  logic [IDX_FIELD_W-1:0] free_index,
    output logic                   done,
    output logic [1:0]             status,
    output logic [IDX_FIELD_W-1:0] alloc_index,
    output logic [COUNT_W-1:0]     in_use,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CAP_W-1:0]       cfg_data
);

    localparam int IDX_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int LINK_W = IDX_W + 1;
    localparam int VB = IDX_W;
    localparam int CAP_MAX = (POOL_DEPTH < 64) ? POOL_DEPTH : 64;
    localparam logic [CAP_W-1:0] CAP_MAX_C = CAP_W'(CAP_MAX);
    localparam logic [IDX_W-1:0] LAST_ENTRY = IDX_W'(POOL_DEPTH - 1);

    // Input register.
    logic                   op_valid_reg, op_valid_next;
    logic                   opcode_reg, opcode_next;
    logic                   present_reg, present_next;
    logic [IDX_FIELD_W-1:0] index_reg, index_next;

    // Free list state.
    logic [CAP_W-1:0]   cap_reg, cap_next;
    logic [IDX_W-1:0]   head_reg, head_next;
    logic               hv_reg, hv_next;
    logic [LINK_W-1:0]  n1_reg, n1_next;
    logic [LINK_W-1:0]  n2_reg, n2_next;
    logic               byp_reg, byp_next;
    logic [COUNT_W-1:0] used_reg, used_next;
    logic               sweep_reg, sweep_next;
    logic [IDX_W-1:0]   cnt_reg, cnt_next;

    // Result register.
    logic                   done_reg, done_next;
    status_t                status_reg, status_next;
    logic [IDX_FIELD_W-1:0] alloc_index_reg, alloc_index_next;
    logic [COUNT_W-1:0]     in_use_reg, in_use_next;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_wr_addr;
    logic [LINK_W-1:0] ram_wr_data;
    logic              ram_rd_en;
    logic [IDX_W-1:0]  ram_rd_addr;
    logic [LINK_W-1:0] ram_rd_data;

    logic              accept;
    logic              cfg_we;
    logic [CAP_W-1:0]  cap_wr;
    logic [LINK_W-1:0] n2_cur;
    logic [IDX_W-1:0]  idx_in;
    logic [LINK_W-1:0] head_link;

    fbfl_link_ram #(
        .DEPTH  (POOL_DEPTH),
        .ADDR_W (IDX_W),
        .DATA_W (LINK_W)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // A pending capacity write keeps new commands out so the two never meet.
    assign busy = sweep_reg || cfg_valid;
    assign cfg_ready = !op_valid_reg;
    assign accept = start && !busy;
    assign cfg_we = cfg_valid && cfg_ready;
    assign cap_wr = (cfg_data > CAP_MAX_C) ? CAP_MAX_C : cfg_data;

    // The link after n1 comes from the read issued by the last alloc, unless a free
    // or a rebuild has since supplied it directly.
    assign n2_cur = byp_reg ? n2_reg : ram_rd_data;
    assign idx_in = IDX_W'(index_reg);
    assign head_link = {hv_reg, head_reg};

    assign done = done_reg;
    assign status = status_reg;
    assign alloc_index = alloc_index_reg;
    assign in_use = in_use_reg;

    always_comb
    begin
        op_valid_next = accept;
        opcode_next = accept ? opcode : opcode_reg;
        present_next = accept ? block_present : present_reg;
        index_next = accept ? free_index : index_reg;

        cap_next = cap_reg;
        head_next = head_reg;
        hv_next = hv_reg;
        n1_next = n1_reg;
        n2_next = n2_reg;
        byp_next = byp_reg;
        used_next = used_reg;
        sweep_next = sweep_reg;
        cnt_next = cnt_reg;

        status_next = STATUS_OK;
        alloc_index_next = '0;

        ram_we = 1'b0;
        ram_wr_addr = idx_in;
        ram_wr_data = head_link;
        ram_rd_en = 1'b0;
        ram_rd_addr = n2_cur[IDX_W-1:0];

        if (sweep_reg)
        begin
            ram_we = 1'b1;
            ram_wr_addr = cnt_reg;
            ram_wr_data = {(cnt_reg != '0) && (32'(cnt_reg) < 32'(cap_reg)),
                           cnt_reg - IDX_W'(1)};
            cnt_next = cnt_reg + IDX_W'(1);
            if (cnt_reg == LAST_ENTRY)
            begin
                sweep_next = 1'b0;
            end
        end
        else if (op_valid_reg)
        begin
            case (opcode_reg)
                OP_ALLOC:
                begin
                    if (!hv_reg)
                    begin
                        status_next = STATUS_EMPTY;
                    end
                    else
                    begin
                        alloc_index_next = IDX_FIELD_W'(head_reg);
                        head_next = n1_reg[IDX_W-1:0];
                        hv_next = n1_reg[VB];
                        // The popped entry is cleared, so any cached link that still
                        // names it now ends the list.
                        ram_we = 1'b1;
                        ram_wr_addr = head_reg;
                        ram_wr_data = '0;
                        n1_next = (n1_reg[IDX_W-1:0] == head_reg) ? '0 : n2_cur;
                        if (n2_cur[IDX_W-1:0] == head_reg)
                        begin
                            n2_next = '0;
                            byp_next = 1'b1;
                        end
                        else
                        begin
                            ram_rd_en = 1'b1;
                            byp_next = 1'b0;
                        end
                        if (used_reg != COUNT_MAX)
                        begin
                            used_next = used_reg + COUNT_W'(1);
                        end
                    end
                end
                OP_FREE:
                begin
                    if (!present_reg)
                    begin
                        status_next = STATUS_NULL_FREE;
                    end
                    else if ({1'b0, index_reg} >= cap_reg || used_reg == '0)
                    begin
                        status_next = STATUS_BAD_FREE;
                    end
                    else
                    begin
                        ram_we = 1'b1;
                        head_next = idx_in;
                        hv_next = 1'b1;
                        n1_next = head_link;
                        // Freeing the head again makes it link to itself.
                        n2_next = (idx_in == head_reg) ? head_link : n1_reg;
                        byp_next = 1'b1;
                        used_next = used_reg - COUNT_W'(1);
                    end
                end
                default:
                begin
                    status_next = STATUS_OK;
                end
            endcase
        end

        if (cfg_we)
        begin
            cap_next = cap_wr;
            head_next = IDX_W'(cap_wr - CAP_W'(1));
            hv_next = (cap_wr != '0);
            n1_next = {(cap_wr > CAP_W'(1)), IDX_W'(cap_wr - CAP_W'(2))};
            n2_next = {(cap_wr > CAP_W'(2)), IDX_W'(cap_wr - CAP_W'(3))};
            byp_next = 1'b1;
            used_next = '0;
            sweep_next = 1'b1;
            cnt_next = '0;
        end

        done_next = op_valid_reg;
        in_use_next = used_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg <= 1'b0;
            cap_reg <= CAP_MAX_C;
            head_reg <= IDX_W'(CAP_MAX - 1);
            hv_reg <= 1'b1;
            n1_reg <= {1'(CAP_MAX > 1), IDX_W'(CAP_MAX - 2)};
            n2_reg <= {1'(CAP_MAX > 2), IDX_W'(CAP_MAX - 3)};
            byp_reg <= 1'b1;
            used_reg <= '0;
            sweep_reg <= 1'b1;
            cnt_reg <= '0;
            done_reg <= 1'b0;
            status_reg <= STATUS_OK;
            alloc_index_reg <= '0;
            in_use_reg <= '0;
        end
        else
        begin
            op_valid_reg <= op_valid_next;
            cap_reg <= cap_next;
            head_reg <= head_next;
            hv_reg <= hv_next;
            n1_reg <= n1_next;
            n2_reg <= n2_next;
            byp_reg <= byp_next;
            used_reg <= used_next;
            sweep_reg <= sweep_next;
            cnt_reg <= cnt_next;
            done_reg <= done_next;
            status_reg <= status_next;
            alloc_index_reg <= alloc_index_next;
            in_use_reg <= in_use_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opcode_reg <= opcode_next;
        present_reg <= present_next;
        index_reg <= index_next;
    end

    // A result beat only follows a command held in the input register.
    a_done_follows_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(op_valid_reg))
        else $error("result beat without a command");

    // Rejected or ignored commands leave the in-use count alone.
    a_fail_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg != STATUS_OK) |-> (used_reg == $past(used_reg)))
        else $error("in-use count changed on a failed command");

    // A nonzero block index is only reported with an ok status.
    a_index_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (alloc_index_reg != '0) |-> (status_reg == STATUS_OK))
        else $error("block index reported with an error status");

    // A rebuild only starts on a capacity write.
    a_rebuild_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(sweep_reg) |-> $past(cfg_valid && cfg_ready))
        else $error("rebuild started without a capacity write");

endmodule

@@ sv/fbfl_link_ram.sv @@
// Link table storage: one write port and one read port with registered read data.
module fbfl_link_ram #(
    parameter int DEPTH = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 7
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ bench/tb_fixed_block_free_list_allocator_core.sv @@
// Self-checking testbench for the fixed-size block free-list allocator core.
module tb_fixed_block_free_list_allocator_core
    import fbfl_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOL_DEPTH = 64;
    localparam int LOG_LIMIT = 20;

    typedef struct packed {
        status_t                status;
        logic [IDX_FIELD_W-1:0] blk;
        logic [COUNT_W-1:0]     count;
    } alloc_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic                   opcode = OP_ALLOC;
    logic                   block_present = 1'b0;
    logic [IDX_FIELD_W-1:0] free_index = '0;
    logic                   done;
    logic [1:0]             status;
    logic [IDX_FIELD_W-1:0] alloc_index;
    logic [COUNT_W-1:0]     in_use;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CAP_W-1:0]       cfg_data = '0;

    // Shadow copy of the free list.
    int unsigned            pool_cap;
    logic [IDX_FIELD_W-1:0] next_free [POOL_DEPTH];
    bit                     next_ok [POOL_DEPTH];
    logic [IDX_FIELD_W-1:0] head_blk;
    bit                     head_ok;
    logic [COUNT_W-1:0]     blocks_in_use;

    alloc_result_t          pending_results [$];
    logic [IDX_FIELD_W-1:0] held_blocks [$];
    int                     mismatches = 0;
    int                     idle_pct = 0;

    fixed_block_free_list_allocator_core #(
        .POOL_DEPTH(POOL_DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .block_present(block_present),
        .free_index   (free_index),
        .done         (done),
        .status       (status),
        .alloc_index  (alloc_index),
        .in_use       (in_use),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #500us;
        $display("Some tests failed");
        $finish;
    end

    function automatic void rebuild_pool(logic [CAP_W-1:0] value);
        pool_cap = (value > CAP_FIELD_MAX) ? CAP_FIELD_MAX : value;
        if (pool_cap > POOL_DEPTH)
        begin
            pool_cap = POOL_DEPTH;
        end
        for (int i = 0; i < POOL_DEPTH; i++)
        begin
            next_ok[i] = (i > 0) && (i < pool_cap);
            next_free[i] = next_ok[i] ? IDX_FIELD_W'(i - 1) : '0;
        end
        head_ok = (pool_cap > 0);
        head_blk = head_ok ? IDX_FIELD_W'(pool_cap - 1) : '0;
        blocks_in_use = '0;
        held_blocks.delete();
    endfunction

    function automatic alloc_result_t predict_command(logic op, logic present,
                                                      logic [IDX_FIELD_W-1:0] idx);
        alloc_result_t          r;
        logic [IDX_FIELD_W-1:0] blk;
        r.blk = '0;
        if (op == OP_ALLOC)
        begin
            if (!head_ok)
            begin
                r.status = STATUS_EMPTY;
            end
            else
            begin
                blk = head_blk;
                head_blk = next_free[blk];
                head_ok = next_ok[blk];
                next_free[blk] = '0;
                next_ok[blk] = 1'b0;
                if (blocks_in_use < COUNT_MAX)
                begin
                    blocks_in_use++;
                end
                r.blk = blk;
                r.status = STATUS_OK;
                held_blocks.push_back(blk);
            end
        end
        else if (!present)
        begin
            r.status = STATUS_NULL_FREE;
        end
        else if (idx >= pool_cap || blocks_in_use == 0)
        begin
            r.status = STATUS_BAD_FREE;
        end
        else
        begin
            // A double free is pushed like any other free.
            next_free[idx] = head_blk;
            next_ok[idx] = head_ok;
            head_blk = idx;
            head_ok = 1'b1;
            blocks_in_use--;
            r.status = STATUS_OK;
            for (int k = 0; k < held_blocks.size(); k++)
            begin
                if (held_blocks[k] == idx)
                begin
                    held_blocks.delete(k);
                    break;
                end
            end
        end
        r.count = blocks_in_use;
        return r;
    endfunction

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= LOG_LIMIT)
        begin
            $display("%0t: mismatch: %s", $time, what);
        end
    endtask

    always @(posedge clk)
    begin
        alloc_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                flag_mismatch("result beat with nothing outstanding");
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                begin
                    flag_mismatch($sformatf("status %0d, wanted %0d", status, want.status));
                end
                if (alloc_index !== want.blk)
                begin
                    flag_mismatch($sformatf("alloc_index %0d, wanted %0d",
                                            alloc_index, want.blk));
                end
                if (in_use !== want.count)
                begin
                    flag_mismatch($sformatf("in_use %0d, wanted %0d", in_use, want.count));
                end
            end
        end
    end

    // Presents one command, waits for it to be taken, then maybe leaves a gap.
    task automatic issue_command(input logic op, input logic present,
                                 input logic [IDX_FIELD_W-1:0] idx);
        int gap;
        start <= 1'b1;
        opcode <= op;
        block_present <= present;
        free_index <= idx;
        do @(posedge clk); while (busy);
        pending_results.push_back(predict_command(op, present, idx));
        gap = 0;
        while (gap < 20 && $urandom_range(99) < idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        drain_results();
        while (busy)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_data <= CAP_W'($urandom);
        rebuild_pool(value);
    endtask

    task automatic test_reset_pool();
        idle_pct = 0;
        issue_command(OP_FREE, 1'b1, 6'd0);      // nothing in use yet
        issue_command(OP_FREE, 1'b0, 6'd0);
        issue_command(OP_ALLOC, 1'b1, 6'h3F);    // unused fields set high
        issue_command(OP_ALLOC, 1'b0, 6'd0);
        issue_command(OP_FREE, 1'b1, 6'd63);
        issue_command(OP_FREE, 1'b0, 6'd63);
        issue_command(OP_ALLOC, 1'b0, 6'h2A);
        issue_command(OP_FREE, 1'b1, 6'd62);
        issue_command(OP_FREE, 1'b1, 6'd63);
        issue_command(OP_FREE, 1'b1, 6'd63);
    endtask

    task automatic test_tiny_pool();
        idle_pct = 0;
        write_capacity(7'd2);
        repeat (3) issue_command(OP_ALLOC, 1'b0, 6'd0);
        issue_command(OP_FREE, 1'b1, 6'd2);      // at capacity
        issue_command(OP_FREE, 1'b1, 6'd63);
        issue_command(OP_FREE, 1'b1, 6'd0);
        issue_command(OP_FREE, 1'b1, 6'd0);      // same block again
        repeat (3) issue_command(OP_ALLOC, 1'b1, 6'd0);
    endtask

    task automatic test_capacity_edges();
        idle_pct = 0;
        write_capacity(7'd0);
        issue_command(OP_ALLOC, 1'b0, 6'd0);
        issue_command(OP_FREE, 1'b1, 6'd0);
        issue_command(OP_FREE, 1'b0, 6'd0);
        write_capacity(7'd127);                  // saturates to a full pool
        issue_command(OP_ALLOC, 1'b0, 6'd0);
        issue_command(OP_FREE, 1'b1, 6'd63);
        write_capacity(7'd1);
        issue_command(OP_ALLOC, 1'b0, 6'd0);
        issue_command(OP_ALLOC, 1'b0, 6'd0);
        issue_command(OP_FREE, 1'b1, 6'd0);
    endtask

    // Allocs at alloc_pct percent; the frees are mostly of blocks really held, with null and stray frees mixed in.
    task automatic random_burst(input int count, input int alloc_pct);
        int pick;
        repeat (count)
        begin
            if ($urandom_range(99) < alloc_pct)
            begin
                issue_command(OP_ALLOC, 1'($urandom_range(1)), 6'($urandom_range(63)));
            end
            else
            begin
                pick = (held_blocks.size() == 0) ? $urandom_range(99, 75) : $urandom_range(99);
                if (pick < 75)
                begin
                    issue_command(OP_FREE, 1'b1,
                                  held_blocks[$urandom_range(held_blocks.size() - 1)]);
                end
                else if (pick < 85)
                begin
                    issue_command(OP_FREE, 1'b0, 6'($urandom_range(63)));
                end
                else
                begin
                    issue_command(OP_FREE, 1'b1, 6'($urandom_range(63)));
                end
            end
        end
    endtask

    task automatic test_random_traffic();
        logic [CAP_W-1:0] settings [8];
        int               fill_len;
        int               idle_choice [3];
        settings = '{7'd64, 7'd1, 7'd5, 7'd127, 7'd17, 7'd65, 7'd2, 7'd0};
        settings[7] = CAP_W'($urandom_range(127));
        idle_choice = '{0, 69, 19};
        for (int k = 0; k < 8; k++)
        begin
            write_capacity(settings[k]);
            // The alloc-heavy stretch runs the pool dry before the mixed one.
            fill_len = pool_cap + pool_cap / 4 + 4;
            idle_pct = idle_choice[(2 * k) % 3];
            random_burst(fill_len, 92);
            idle_pct = idle_choice[(2 * k + 1) % 3];
            random_burst((fill_len > 70) ? 30 : 100 - fill_len, 45);
        end
    endtask

    initial
    begin
        rebuild_pool(7'd64);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_pool();
        test_tiny_pool();
        test_capacity_edges();
        test_random_traffic();
        drain_results();
        if (mismatches == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
